FILE: rtl/lrwa_pkg.sv
`timescale 1ns / 1ps

package lrwa_pkg;

    // widths fixed by the frame and result formats
    localparam int SAMPLE_W = 15;
    localparam int SPEED_W  = 19;
    localparam int FRAC_W   = 4;
    localparam int HELD_W   = 4;
    localparam int RAW_W    = 16;

    // speed level code, bits 3:2 of the status byte
    typedef enum logic [1:0] {
        LVL_IDLE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_HIGH = 2'd3
    } t_level;

    // configuration register indexes
    localparam logic [1:0] CFG_DEF_LOW  = 2'd0;
    localparam logic [1:0] CFG_DEF_MID  = 2'd1;
    localparam logic [1:0] CFG_DEF_HIGH = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] DEF_LOW_RST  = 15'd150;
    localparam logic [SAMPLE_W-1:0] DEF_MID_RST  = 15'd180;
    localparam logic [SAMPLE_W-1:0] DEF_HIGH_RST = 15'd300;

endpackage

FILE: rtl/lrwa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lrwa_div #(
    parameter int QW = 23,
    parameter int DW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [QW-1:0] o_quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   n_shift;
    logic [DW:0]   n_diff;
    logic          n_ge;

    assign n_shift = {r_rem, r_quo[QW-1]};
    assign n_diff  = n_shift - {1'b0, r_div};
    assign n_ge    = (n_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DW-1:0] : n_shift[DW-1:0];
                r_quo <= {r_quo[QW-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/level_reset_window_average.sv
`timescale 1ns / 1ps
// Flow: a level change or an empty-window default goes from S_IDLE to S_DONE and then into the
//   output register; a mean with a new sample passes S_UPD, S_DIVGO, S_DIV and S_DONE before
//   the output register, and a repeated mean skips S_UPD (QW = sum width + 4).
// One request at a time: the input is ready only in S_IDLE, so a new request is taken only
//   after the last one has been loaded into the output register. The bit-serial divider gives
//   one quotient bit per cycle; a result held by a full output register stalls the next
//   request until the register frees.
// Reset (synchronous, active low) empties the window, sets the level to idle and loads
//   the default speeds 150 / 180 / 300; the sample memory itself is not cleared.
module level_reset_window_average #(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // status_byte, speed_low_byte, speed_high_byte
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // mean_speed[18:0], speed_valid, samples_held[3:0]
    output logic        m_axis_tuser,  // used_default
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int SW    = lrwa_pkg::SAMPLE_W;
    localparam int SUMW  = $clog2(WINDOW_LENGTH * ((1 << SW) - 1) + 1);
    localparam int QW    = SUMW + lrwa_pkg::FRAC_W;
    localparam int CNTW  = $clog2(WINDOW_LENGTH + 1);
    localparam int SLOTW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DIVGO,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // config
    logic [SW-1:0] r_def_low, r_def_mid, r_def_high;

    // window bookkeeping
    logic [SW-1:0]    r_mem [WINDOW_LENGTH];
    logic [SW-1:0]    r_rd_data;
    logic [CNTW-1:0]  r_count;
    logic [SUMW-1:0]  r_sum;
    logic [SLOTW-1:0] r_oldest;
    lrwa_pkg::t_level r_level;
    logic             r_valid_flag;

    // request in flight
    logic [SW-1:0] r_sample;
    logic [lrwa_pkg::SPEED_W-1:0] r_res_speed;
    logic          r_res_used;

    // output register
    logic          r_m_valid;
    logic [lrwa_pkg::SPEED_W-1:0] r_m_speed;
    logic          r_m_used;
    logic          r_m_vflag;
    logic [lrwa_pkg::HELD_W-1:0]  r_m_held;
    logic          out_load;

    // divider
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_quo;

    // decode of the incoming frame
    lrwa_pkg::t_level in_level;
    logic [lrwa_pkg::RAW_W-1:0] in_raw;
    logic in_pos;
    logic in_change;
    logic accept;

    assign in_level  = lrwa_pkg::t_level'(s_axis_tdata[3:2]);
    assign in_raw    = s_axis_tdata[23:8];
    assign in_pos    = (in_raw != '0) && !in_raw[lrwa_pkg::RAW_W-1];
    assign in_change = (in_level != r_level) && (in_level != lrwa_pkg::LVL_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    function automatic logic [lrwa_pkg::SPEED_W-1:0] level_default16(
        input lrwa_pkg::t_level lvl,
        input logic [SW-1:0] d_low,
        input logic [SW-1:0] d_mid,
        input logic [SW-1:0] d_high
    );
        logic [SW-1:0] d;
        case (lvl)
            lrwa_pkg::LVL_HIGH: d = d_high;
            lrwa_pkg::LVL_MID:  d = d_mid;
            default:            d = d_low;
        endcase
        return {d, {lrwa_pkg::FRAC_W{1'b0}}};
    endfunction

    // next slot, fill state and oldest index for a positive sample
    logic             full;
    logic [SLOTW:0]   n_fill_wide;
    logic [SLOTW-1:0] n_slot;
    logic [SLOTW-1:0] n_oldest_inc;

    assign full         = (r_count == CNTW'(WINDOW_LENGTH));
    assign n_fill_wide  = {1'b0, r_oldest} + (SLOTW + 1)'(r_count);
    assign n_oldest_inc = (r_oldest == SLOTW'(WINDOW_LENGTH - 1)) ? '0 : r_oldest + 1'b1;

    always_comb begin
        if (full) begin
            n_slot = r_oldest;
        end else if (n_fill_wide >= (SLOTW + 1)'(WINDOW_LENGTH)) begin
            n_slot = SLOTW'(n_fill_wide - (SLOTW + 1)'(WINDOW_LENGTH));
        end else begin
            n_slot = n_fill_wide[SLOTW-1:0];
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_mem[n_slot] <= r_sample;
        end
        r_rd_data <= r_mem[r_oldest];
    end

    assign div_start = (r_state == S_DIVGO);

    lrwa_div #(
        .QW (QW),
        .DW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, {lrwa_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_def_low    <= lrwa_pkg::DEF_LOW_RST;
            r_def_mid    <= lrwa_pkg::DEF_MID_RST;
            r_def_high   <= lrwa_pkg::DEF_HIGH_RST;
            r_count      <= '0;
            r_sum        <= '0;
            r_oldest     <= '0;
            r_level      <= lrwa_pkg::LVL_IDLE;
            r_valid_flag <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lrwa_pkg::CFG_DEF_LOW:  r_def_low  <= i_cfg_data;
                    lrwa_pkg::CFG_DEF_MID:  r_def_mid  <= i_cfg_data;
                    lrwa_pkg::CFG_DEF_HIGH: r_def_high <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= in_raw[SW-1:0];
                        if (in_change) begin
                            r_count      <= '0;
                            r_sum        <= '0;
                            r_oldest     <= '0;
                            r_level      <= in_level;
                            r_valid_flag <= 1'b0;
                            r_res_speed  <= level_default16(in_level, r_def_low,
                                                            r_def_mid, r_def_high);
                            r_res_used   <= 1'b1;
                            r_state      <= S_DONE;
                        end else if (in_pos) begin
                            r_state <= S_UPD;
                        end else if (r_count != '0) begin
                            r_state <= S_DIVGO;
                        end else begin
                            r_res_speed <= level_default16(r_level, r_def_low,
                                                           r_def_mid, r_def_high);
                            r_res_used  <= 1'b1;
                            r_state     <= S_DONE;
                        end
                    end
                end
                S_UPD: begin
                    // r_rd_data holds the oldest entry, used only when the window is full
                    r_valid_flag <= 1'b1;
                    if (full) begin
                        r_sum    <= r_sum - SUMW'(r_rd_data) + SUMW'(r_sample);
                        r_oldest <= n_oldest_inc;
                    end else begin
                        r_sum   <= r_sum + SUMW'(r_sample);
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res_speed <= div_quo[lrwa_pkg::SPEED_W-1:0];
                        r_res_used  <= 1'b0;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_m_speed <= r_res_speed;
                        r_m_used  <= r_res_used;
                        r_m_vflag <= r_valid_flag;
                        r_m_held  <= lrwa_pkg::HELD_W'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_held, r_m_vflag, r_m_speed};
    assign m_axis_tuser  = r_m_used;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(WINDOW_LENGTH))
        else $error("window count beyond window length");

    a_oldest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= SLOTW'(WINDOW_LENGTH - 1))
        else $error("oldest slot out of range");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !r_valid_flag)
        else $error("valid flag disagrees with window fill");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_start_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_DIVGO) && r_valid_flag)
        else $error("window update not followed by divide start");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WLEN = 10;
    localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind it, write is dropped
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 226;

    // status byte in the low bits, as on s_axis_tdata
    typedef struct packed {
        logic [7:0] speed_hi;
        logic [7:0] speed_lo;
        logic [7:0] status;
    } t_frame;

    typedef struct {
        t_frame frame;
        int     gap;
    } t_pending;

    typedef struct {
        logic [lrwa_pkg::SPEED_W-1:0] mean;
        logic                         used_def;
        logic                         valid;
        logic [lrwa_pkg::HELD_W-1:0]  held;
    } t_speed_result;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic [23:0] s_axis_tdata   = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index    = '0;
    logic [14:0] i_cfg_data     = '0;

    level_reset_window_average #(
        .WINDOW_LENGTH(WLEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    t_pending      pending_frames[$];
    t_speed_result expected_speeds[$];
    int            n_mismatch = 0;
    int            n_accepted = 0;
    int            n_results  = 0;

    // predictor state
    logic [lrwa_pkg::SAMPLE_W-1:0] def_low  = lrwa_pkg::DEF_LOW_RST;
    logic [lrwa_pkg::SAMPLE_W-1:0] def_mid  = lrwa_pkg::DEF_MID_RST;
    logic [lrwa_pkg::SAMPLE_W-1:0] def_high = lrwa_pkg::DEF_HIGH_RST;
    logic [lrwa_pkg::SAMPLE_W-1:0] win_samples[WLEN];
    int                            win_held   = 0;
    int                            win_sum    = 0;
    int                            win_oldest = 0;
    lrwa_pkg::t_level              held_level = lrwa_pkg::LVL_IDLE;
    logic                          seen_valid = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [lrwa_pkg::SAMPLE_W-1:0] level_default(lrwa_pkg::t_level lvl);
        case (lvl)
            lrwa_pkg::LVL_HIGH: return def_high;
            lrwa_pkg::LVL_MID:  return def_mid;
            default:            return def_low;
        endcase
    endfunction

    function automatic t_speed_result predict_speed(t_frame f);
        lrwa_pkg::t_level lvl;
        logic [15:0]      raw;
        int               slot;
        t_speed_result    r;
        lvl = lrwa_pkg::t_level'(f.status[3:2]);
        raw = {f.speed_hi, f.speed_lo};
        r.used_def = 1'b0;
        if (lvl != held_level && lvl != lrwa_pkg::LVL_IDLE) begin
            win_held   = 0;
            win_sum    = 0;
            win_oldest = 0;
            held_level = lvl;
            seen_valid = 1'b0;
            r.mean     = {level_default(lvl), 4'b0};
            r.used_def = 1'b1;
        end else if (raw != 16'd0 && !raw[15]) begin
            seen_valid = 1'b1;
            if (win_held >= WLEN) begin
                // full: overwrite the oldest slot
                slot = win_oldest;
                win_sum = win_sum - int'(win_samples[slot]) + int'(raw);
                win_samples[slot] = raw[14:0];
                win_oldest = (slot + 1) % WLEN;
            end else begin
                slot = (win_oldest + win_held) % WLEN;
                win_samples[slot] = raw[14:0];
                win_sum += int'(raw);
                win_held++;
            end
            r.mean = lrwa_pkg::SPEED_W'((win_sum * 16) / win_held);
        end else if (win_held > 0) begin
            r.mean = lrwa_pkg::SPEED_W'((win_sum * 16) / win_held);
        end else begin
            r.mean     = {level_default(held_level), 4'b0};
            r.used_def = 1'b1;
        end
        r.valid = seen_valid;
        r.held  = lrwa_pkg::HELD_W'(win_held);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        n_mismatch++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_speeds.insert(expected_speeds.size(),
                                       predict_speed(t_frame'(s_axis_tdata)));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_frames.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_frames[0].gap > 0) begin
                    pending_frames[0].gap--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata  <= pending_frames[0].frame;
                    s_axis_tvalid <= 1'b1;
                    pending_frames.delete(0);
                end
            end
        end
    end

    // long receiver hold-off, once, so the block backs up onto its input
    int  hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    int rx_wait = 0;
    always @(posedge i_clk) begin
        t_speed_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_speeds.size() == 0) begin
                    report_mismatch("result with no request pending", m_axis_tdata, 0);
                end else begin
                    want = expected_speeds[0];
                    expected_speeds.delete(0);
                    if (m_axis_tdata[18:0] != want.mean)
                        report_mismatch("mean_speed", m_axis_tdata[18:0], want.mean);
                    if (m_axis_tuser != want.used_def)
                        report_mismatch("used_default", m_axis_tuser, want.used_def);
                    if (m_axis_tdata[19] != want.valid)
                        report_mismatch("speed_valid", m_axis_tdata[19], want.valid);
                    if (m_axis_tdata[23:20] != want.held)
                        report_mismatch("samples_held", m_axis_tdata[23:20], want.held);
                end
                rx_wait = ((n_results / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_default(input logic [1:0] idx, input logic [14:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lrwa_pkg::CFG_DEF_LOW:  def_low  = val;
            lrwa_pkg::CFG_DEF_MID:  def_mid  = val;
            lrwa_pkg::CFG_DEF_HIGH: def_high = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_speeds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_frame(input logic [7:0] status, input logic [15:0] sample,
                               input int gap);
        t_pending p;
        p.frame = {sample[15:8], sample[7:0], status};
        p.gap   = gap;
        pending_frames.insert(pending_frames.size(), p);
    endtask

    function automatic logic [15:0] draw_sample();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 35) return 16'($urandom_range(1, 200));
        if (p < 55) return 16'($urandom_range(1, 32767));
        if (p < 70) return 16'($urandom_range(32000, 32767));
        if (p < 80) return 16'h0000;
        return 16'($urandom_range(32768, 65535));
    endfunction

    initial begin
        lrwa_pkg::t_level gen_level;
        logic [1:0]       lvl_bits;
        int unsigned      p;
        int               gap;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-window defaults, level changes, idle is no change, window wrap
        queue_frame(8'h00, 16'h0000, 0);
        queue_frame(8'h00, 16'h8000, 2);
        queue_frame(8'hF3, 16'hFFFF, 0);
        queue_frame(8'h04, 16'h0064, 0);
        queue_frame(8'h04, 16'h0001, 1);
        queue_frame(8'h04, 16'h7FFF, 0);
        for (int i = 0; i < 8; i++)
            queue_frame(8'h00, 16'($urandom_range(1, 32767)), $urandom_range(0, 3));
        queue_frame(8'h04, 16'h7FFF, 0);
        queue_frame(8'h04, 16'hFFFF, 0);
        queue_frame(8'hFF, 16'h0005, 0);
        queue_frame(8'hFB, 16'h0000, 0);
        queue_frame(8'h08, 16'h8001, 0);
        queue_frame(8'h0C, 16'h00FF, 0);
        queue_frame(8'h0C, 16'h0100, 0);
        queue_frame(8'h04, 16'h7FFF, 0);

        gen_level = lrwa_pkg::LVL_LOW;
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_default(lrwa_pkg::CFG_DEF_LOW, 15'h0000);
                    write_default(lrwa_pkg::CFG_DEF_MID, 15'h7FFF);
                    write_default(lrwa_pkg::CFG_DEF_HIGH, 15'h0001);
                    write_default(CFG_UNUSED, 15'h5A5A);
                end
                2: begin
                    write_default(lrwa_pkg::CFG_DEF_LOW, 15'h7FFF);
                    write_default(lrwa_pkg::CFG_DEF_MID, 15'h0000);
                    write_default(lrwa_pkg::CFG_DEF_HIGH, 15'h7FFF);
                end
                4: begin
                    write_default(lrwa_pkg::CFG_DEF_LOW, lrwa_pkg::DEF_LOW_RST);
                    write_default(lrwa_pkg::CFG_DEF_MID, lrwa_pkg::DEF_MID_RST);
                    write_default(lrwa_pkg::CFG_DEF_HIGH, lrwa_pkg::DEF_HIGH_RST);
                    write_default(CFG_UNUSED, 15'h7FFF);
                end
                default: begin
                    write_default(lrwa_pkg::CFG_DEF_LOW, 15'($urandom));
                    write_default(lrwa_pkg::CFG_DEF_MID, 15'($urandom));
                    write_default(lrwa_pkg::CFG_DEF_HIGH, 15'($urandom));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                p = $urandom_range(0, 99);
                if (p < 4)
                    gen_level = lrwa_pkg::t_level'($urandom_range(1, 3));
                // idle code now and then: not a level change
                lvl_bits = (p >= 4 && p < 16) ? lrwa_pkg::LVL_IDLE : gen_level;
                gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 6);
                queue_frame({4'($urandom), lvl_bits, 2'($urandom)}, draw_sample(), gap);
            end
        end
        wait_drained();

        if (n_mismatch == 0) begin
            $display("level_reset_window_average test passed");
        end else begin
            $display("level_reset_window_average test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("level_reset_window_average test failed");
        $finish;
    end

endmodule

FILE: level_reset_window_average.f
rtl/lrwa_pkg.sv
rtl/lrwa_div.sv
rtl/level_reset_window_average.sv
sim/tb.sv
